@@ sv/shqp_pkg.sv @@
// shared constants and types for the string hash quadratic probe insert unit
package shqp_pkg;

    localparam int DEF_MAX_SLOTS = 4096;
    localparam int HASH_W        = 64;
    localparam int CHAR_W        = 7;
    localparam int SLOT_W        = 12;
    localparam int TSIZE_W       = 13;
    localparam int S_DATA_W      = 8;
    localparam int M_DATA_W      = 16;
    localparam int BITCNT_W      = $clog2(HASH_W);

    localparam logic [TSIZE_W-1:0] TSIZE_RESET = TSIZE_W'(11);

    // hash multiplier 37 is applied as (h << 5) + (h << 2) + h
    localparam int HASH_SH_HI = 5;
    localparam int HASH_SH_LO = 2;

    typedef logic [TSIZE_W-1:0] tsize_t;
    typedef logic [HASH_W-1:0]  hash_t;

    typedef enum logic [4:0] {
        ST_CLEAR  = 5'b00001,
        ST_IDLE   = 5'b00010,
        ST_DIV    = 5'b00100,
        ST_PROBE  = 5'b01000,
        ST_RESULT = 5'b10000
    } state_t;

endpackage

@@ sv/string_hash_quadratic_probe_insert_unit.sv @@
// string hash with quadratic probing insertion into an occupancy bitmap memory
// a non-final character is folded into the hash when accepted; a final character's result
//   passes the bit-serial remainder of the 64-bit hash by the table size, then k probe
//   reads, each checked on its registered read word, then the output register;
//   k slots read, at most table_size + 1
// a final character holds off further input until its result is in the output register,
//   held by the remainder loop and the single read port of the bitmap (one slot a cycle)
// reset: clears the hash and sets table_size to 11, then sweeps all MAX_SLOTS bitmap slots
//   to zero, one slot a cycle, with s_tready low; config writes still taken
module string_hash_quadratic_probe_insert_unit #(
    parameter int MAX_SLOTS = shqp_pkg::DEF_MAX_SLOTS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // configuration write: table_size
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [shqp_pkg::TSIZE_W-1:0]  cfg_data,
    // input words
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [shqp_pkg::S_DATA_W-1:0] s_tdata,   // [6:0] char_code, [7] zero
    input  logic                          s_tlast,   // last_char
    // result words
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [shqp_pkg::M_DATA_W-1:0] m_tdata,   // [11:0] slot, [15:12] zero
    output logic                          m_tuser    // placed
);
    import shqp_pkg::*;

    localparam int AW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int NW = $clog2(MAX_SLOTS + 1);
    localparam int PW = NW + 1;
    localparam int LW = $clog2(MAX_SLOTS + 2);

    state_t state_reg, state_next;

    tsize_t                tsize_reg, tsize_next;
    hash_t                 hash_reg, hash_next;
    logic [BITCNT_W-1:0]   bitcnt_reg, bitcnt_next;
    logic [NW-1:0]         rem_reg, rem_next;
    logic [AW-1:0]         clr_addr_reg, clr_addr_next;

    logic [AW-1:0]         home_reg, home_next;
    logic [AW-1:0]         cand_reg, cand_next;
    logic [AW-1:0]         sq_reg, sq_next;
    logic [AW-1:0]         odd_reg, odd_next;
    logic                  sign_reg, sign_next;
    logic [LW-1:0]         issue_left_reg, issue_left_next;
    logic                  chk_valid_reg, chk_valid_next;
    logic [AW-1:0]         chk_addr_reg, chk_addr_next;

    logic [AW-1:0]         res_slot_reg, res_slot_next;
    logic                  res_placed_reg, res_placed_next;

    logic                  m_tvalid_reg, m_tvalid_next;
    logic [SLOT_W-1:0]     m_slot_reg, m_slot_next;
    logic                  m_placed_reg, m_placed_next;

    logic                  occ_mem [MAX_SLOTS];
    logic                  rd_data_reg;
    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic                  mem_wdata;

    logic [NW-1:0]         n_eff;
    logic                  n_is_one;
    logic [PW-1:0]         rem_sh;
    logic [PW-1:0]         plus_w, minus_w, sq_w, odd_w;
    logic [AW-1:0]         plus_idx, minus_idx, sq_upd, odd_upd;
    logic [AW-1:0]         sq_init, odd_init;
    logic                  s_acc, found;

    // effective table size: zero reads as one, large values saturate
    always_comb begin
        if (tsize_reg == '0) begin
            n_eff = NW'(1);
        end else if (32'(tsize_reg) > 32'(MAX_SLOTS)) begin
            n_eff = NW'(MAX_SLOTS);
        end else begin
            n_eff = NW'(tsize_reg);
        end
    end

    assign n_is_one = (n_eff == NW'(1));

    // one remainder bit per cycle
    assign rem_sh   = {rem_reg, hash_reg[HASH_W-1]};
    assign rem_next = (rem_sh >= PW'(n_eff)) ? NW'(rem_sh - PW'(n_eff)) : NW'(rem_sh);

    // probe addresses, all terms already below the table size
    always_comb begin
        plus_w = PW'(home_reg) + PW'(sq_reg);
        if (plus_w >= PW'(n_eff)) begin
            plus_w = plus_w - PW'(n_eff);
        end
        if (home_reg >= sq_reg) begin
            minus_w = PW'(home_reg) - PW'(sq_reg);
        end else begin
            minus_w = PW'(home_reg) + PW'(n_eff) - PW'(sq_reg);
        end
        sq_w = PW'(sq_reg) + PW'(odd_reg);
        if (sq_w >= PW'(n_eff)) begin
            sq_w = sq_w - PW'(n_eff);
        end
        odd_w = PW'(odd_reg) + PW'(2);
        if (n_is_one) begin
            odd_w = '0;
        end else if (odd_w >= PW'(n_eff)) begin
            odd_w = odd_w - PW'(n_eff);
        end
        plus_idx  = AW'(plus_w);
        minus_idx = AW'(minus_w);
        sq_upd    = AW'(sq_w);
        odd_upd   = AW'(odd_w);
    end

    // 1 mod n and 3 mod n for the first square and its step
    always_comb begin
        sq_init = n_is_one ? '0 : AW'(1);
        if (n_is_one || n_eff == NW'(3)) begin
            odd_init = '0;
        end else if (n_eff == NW'(2)) begin
            odd_init = AW'(1);
        end else begin
            odd_init = AW'(3);
        end
    end

    assign s_acc = s_tvalid && s_tready;
    assign found = chk_valid_reg && !rd_data_reg;

    always_comb begin
        state_next      = state_reg;
        tsize_next      = tsize_reg;
        hash_next       = hash_reg;
        bitcnt_next     = bitcnt_reg;
        clr_addr_next   = clr_addr_reg;
        home_next       = home_reg;
        cand_next       = cand_reg;
        sq_next         = sq_reg;
        odd_next        = odd_reg;
        sign_next       = sign_reg;
        issue_left_next = issue_left_reg;
        chk_valid_next  = chk_valid_reg;
        chk_addr_next   = chk_addr_reg;
        res_slot_next   = res_slot_reg;
        res_placed_next = res_placed_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_slot_next     = m_slot_reg;
        m_placed_next   = m_placed_reg;
        mem_we          = 1'b0;
        mem_waddr       = chk_addr_reg;
        mem_wdata       = 1'b1;

        if (cfg_valid && cfg_ready) begin
            tsize_next = cfg_data;
        end

        case (state_reg)
            ST_CLEAR: begin
                mem_we        = 1'b1;
                mem_waddr     = clr_addr_reg;
                mem_wdata     = 1'b0;
                clr_addr_next = clr_addr_reg + AW'(1);
                if (clr_addr_reg == AW'(MAX_SLOTS - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_acc) begin
                    hash_next = (hash_reg << HASH_SH_HI) + (hash_reg << HASH_SH_LO)
                              + hash_reg + HASH_W'(s_tdata[CHAR_W-1:0]);
                    if (s_tlast) begin
                        bitcnt_next = '0;
                        state_next  = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                // shifting out all 64 bits leaves the running hash at zero
                hash_next   = hash_reg << 1;
                bitcnt_next = bitcnt_reg + BITCNT_W'(1);
                if (bitcnt_reg == BITCNT_W'(HASH_W - 1)) begin
                    home_next       = AW'(rem_next);
                    cand_next       = AW'(rem_next);
                    sq_next         = sq_init;
                    odd_next        = odd_init;
                    sign_next       = 1'b0;
                    issue_left_next = LW'(n_eff) + LW'(1);
                    chk_valid_next  = 1'b0;
                    state_next      = ST_PROBE;
                end
            end
            ST_PROBE: begin
                if (found) begin
                    mem_we          = 1'b1;
                    res_slot_next   = chk_addr_reg;
                    res_placed_next = 1'b1;
                    state_next      = ST_RESULT;
                end else if (!chk_valid_reg && issue_left_reg == '0) begin
                    res_slot_next   = '0;
                    res_placed_next = 1'b0;
                    state_next      = ST_RESULT;
                end else if (issue_left_reg != '0) begin
                    // cand_reg is read this cycle, its word is checked next cycle
                    chk_valid_next  = 1'b1;
                    chk_addr_next   = cand_reg;
                    issue_left_next = issue_left_reg - LW'(1);
                    sign_next       = !sign_reg;
                    if (sign_reg) begin
                        cand_next = minus_idx;
                        sq_next   = sq_upd;
                        odd_next  = odd_upd;
                    end else begin
                        cand_next = plus_idx;
                    end
                end else begin
                    chk_valid_next = 1'b0;
                end
            end
            ST_RESULT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_slot_next   = SLOT_W'(res_slot_reg);
                    m_placed_next = res_placed_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            tsize_reg     <= TSIZE_RESET;
            hash_reg      <= '0;
            clr_addr_reg  <= '0;
            chk_valid_reg <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            tsize_reg     <= tsize_next;
            hash_reg      <= hash_next;
            clr_addr_reg  <= clr_addr_next;
            chk_valid_reg <= chk_valid_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        bitcnt_reg     <= bitcnt_next;
        rem_reg        <= (state_reg == ST_DIV) ? rem_next : '0;
        home_reg       <= home_next;
        cand_reg       <= cand_next;
        sq_reg         <= sq_next;
        odd_reg        <= odd_next;
        sign_reg       <= sign_next;
        issue_left_reg <= issue_left_next;
        chk_addr_reg   <= chk_addr_next;
        res_slot_reg   <= res_slot_next;
        res_placed_reg <= res_placed_next;
        m_slot_reg     <= m_slot_next;
        m_placed_reg   <= m_placed_next;
    end

    // occupancy bitmap, one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            occ_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= occ_mem[cand_reg];
    end

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = M_DATA_W'(m_slot_reg);
    assign m_tuser   = m_placed_reg;

    a_rem_below_size: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> (rem_reg < n_eff))
        else $error("remainder not below table size");

    a_hash_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(state_reg) == ST_DIV && state_reg == ST_PROBE) |-> (hash_reg == '0))
        else $error("running hash not cleared after remainder pass");

    a_probe_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_PROBE && chk_valid_reg) |-> (NW'(chk_addr_reg) < n_eff))
        else $error("probe address beyond table size");

    a_write_states: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> (state_reg == ST_CLEAR || (state_reg == ST_PROBE && found)))
        else $error("bitmap written outside clear or placement");

    a_fail_slot_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && !m_placed_reg) |-> (m_slot_reg == '0))
        else $error("failed insert reports nonzero slot");

endmodule
